[src/rstt_pkg.sv]
// ----------------------------------------------------------------------------
// rstt_pkg: ride state and time tracker types and constants
// Word formats, event and register codes, state encoding and the fixed
// arithmetic constants shared across the tracker.
// ----------------------------------------------------------------------------
package rstt_pkg;

  localparam int NUM_STATES = 5;

  // one-hot riding state, bit position equals the reported code
  typedef enum logic [NUM_STATES-1:0] {
    ST_NOLINK = 5'b00001,
    ST_BREAK  = 5'b00010,
    ST_STOP   = 5'b00100,
    ST_COAST  = 5'b01000,
    ST_POWER  = 5'b10000
  } drv_state_t;

  localparam int ST_IDX_BREAK = 1;
  localparam int ST_IDX_STOP  = 2;
  localparam int ST_IDX_COAST = 3;
  localparam int ST_IDX_POWER = 4;

  localparam logic [2:0] ST_CODE_NOLINK = 3'd0;
  localparam logic [2:0] ST_CODE_BREAK  = 3'd1;
  localparam logic [2:0] ST_CODE_STOP   = 3'd2;
  localparam logic [2:0] ST_CODE_COAST  = 3'd3;
  localparam logic [2:0] ST_CODE_POWER  = 3'd4;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_CONNECT    = 3'd1;
  localparam logic [2:0] OP_DISCONNECT = 3'd2;
  localparam logic [2:0] OP_EXTEND     = 3'd3;
  localparam logic [2:0] OP_TOGGLE     = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;

  localparam logic [1:0] KIND_ALL      = 2'd0;
  localparam logic [1:0] KIND_NO_BREAK = 2'd1;

  localparam logic [1:0] ICON_NEUTRAL  = 2'd0;
  localparam logic [1:0] ICON_OK       = 2'd1;
  localparam logic [1:0] ICON_WARN     = 2'd2;
  localparam logic [1:0] ICON_CRIT     = 2'd3;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_CADENCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_CADENCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_MINUTES   = 3'd5;

  localparam logic [13:0] START_SPEED_RST   = 14'd550;
  localparam logic [13:0] STOP_SPEED_RST    = 14'd30;
  localparam logic [8:0]  COAST_CADENCE_RST = 9'd40;
  localparam logic [8:0]  POWER_CADENCE_RST = 9'd50;
  localparam logic [23:0] BREAK_DELAY_RST   = 24'd120000;
  localparam logic [7:0]  OFF_MINUTES_RST   = 8'd50;

  localparam logic [15:0] MS_PER_MIN     = 16'd60000;
  localparam logic [7:0]  OFF_NEVER      = 8'd255;
  localparam logic [7:0]  OFF_MAX        = 8'd254;
  localparam logic [7:0]  RESUME_MINUTES = 8'd5;
  localparam logic [32:0] BLINK_MS       = 33'd60000;
  localparam logic [32:0] CRIT_MS        = 33'd10000;

  // x / 1000 = (x * DIV1000_RECIP) >> 38, exact for 32-bit x
  localparam logic [28:0] DIV1000_RECIP  = 29'd274877907;
  localparam int          DIV1000_SHIFT  = 38;
  // x / 60000 = (x * DIV60K_RECIP) >> 40, exact for x below TOGGLE_SAT_MS
  localparam logic [24:0] DIV60K_RECIP   = 25'd18325194;
  localparam int          DIV60K_SHIFT   = 40;
  localparam logic [31:0] TOGGLE_SAT_MS  = 32'd15000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [13:0] speed;
    logic [8:0]  cadence;
    logic [1:0]  slot;
    logic [1:0]  avg_kind;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  drive_state;
    logic [1:0]  icon_color;
    logic        sleep_request;
    logic [7:0]  off_minutes_now;
    logic [22:0] time_seconds;
  } out_word_t;

  function automatic logic [2:0] state_code(input drv_state_t s);
    logic [2:0] code;
    case (s)
      ST_NOLINK: code = ST_CODE_NOLINK;
      ST_BREAK:  code = ST_CODE_BREAK;
      ST_STOP:   code = ST_CODE_STOP;
      ST_COAST:  code = ST_CODE_COAST;
      ST_POWER:  code = ST_CODE_POWER;
      default:   code = ST_CODE_NOLINK;
    endcase
    return code;
  endfunction

  function automatic logic [23:0] min_to_ms(input logic [7:0] m);
    return 24'(m) * 24'(MS_PER_MIN);
  endfunction

endpackage

[src/ride_state_time_tracker.sv]
// ----------------------------------------------------------------------------
// ride_state_time_tracker: riding state machine and per-slot state timers
// Tracks the riding state, per-state millisecond counters for each summary
// slot, stop-to-break moves, auto-off minutes, icon color and slot reads.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result side does not stall and passes it
// through three registered stages: an input register, one stage that applies
// the event to the state and all slot counters in parallel, and a result stage
// that divides the read time and the blink timer by 1000 with reciprocal multipliers.
// Back-pressure on the result side stalls the three stages in place; with
// out_ready held high the sustained rate is one word per cycle.
// Configuration writes take effect at once and are meant for idle periods;
// writing initial_off_minutes also reloads the live auto-off minute count.
module ride_state_time_tracker
  import rstt_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef struct packed {
    logic [2:0]  drive_state;
    logic [1:0]  icon_base;
    logic        blink;
    logic        crit;
    logic        sleep;
    logic [7:0]  off;
    logic [31:0] el;
    logic [31:0] t;
  } mid_t;

  // config registers
  logic [13:0] start_speed_r, stop_speed_r;
  logic [8:0]  coast_cad_r, power_cad_r;
  logic [23:0] break_delay_r;

  // tracker state
  drv_state_t  cur_r, cur_nxt, held_r, held_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [31:0] last_r, last_nxt, stop_r, stop_nxt;
  logic [31:0] cnt_r   [NUM_SLOTS][NUM_STATES];
  logic [31:0] cnt_nxt [NUM_SLOTS][NUM_STATES];

  // pipeline
  logic      s1_vld_r, s2_vld_r, out_vld_r;
  in_word_t  in_q_r;
  mid_t      mid_r, mid_nxt;
  out_word_t out_r, out_nxt;
  logic      out_adv, s2_adv;

  logic [48:0] tog_prod;
  logic [60:0] prod_t, prod_el;

  assign out_adv  = !out_vld_r || out_ready;
  assign s2_adv   = s1_vld_r && (!s2_vld_r || out_adv);
  assign in_ready = !s1_vld_r || s2_adv;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    logic [31:0] delta, el, el2, amt, stop_sum;
    logic [23:0] lim_old, lim_new;
    logic        brk_move, sleep, in_rng;
    logic [31:0] row [NUM_STATES];
    logic [31:0] t;

    cur_nxt  = cur_r;
    held_nxt = held_r;
    off_nxt  = off_r;
    last_nxt = last_r;
    stop_nxt = stop_r;
    brk_move = 1'b0;
    sleep    = 1'b0;
    delta    = in_q_r.now_ms - last_r;
    el       = in_q_r.now_ms - stop_r;
    lim_old  = min_to_ms(off_r);
    tog_prod = 49'(el[23:0]) * 49'(DIV60K_RECIP);

    case (in_q_r.op)
      OP_TICK: begin
        last_nxt = in_q_r.now_ms;
        if (cur_r == ST_COAST || cur_r == ST_POWER) begin
          stop_nxt = in_q_r.now_ms;
          if (in_q_r.speed < stop_speed_r) begin
            cur_nxt = ST_STOP;
          end else if (in_q_r.cadence < coast_cad_r && cur_r == ST_POWER) begin
            cur_nxt = ST_COAST;
          end else if (in_q_r.cadence > power_cad_r && cur_r == ST_COAST) begin
            cur_nxt = ST_POWER;
          end
        end else begin
          brk_move = (cur_r == ST_STOP) && (el > {8'b0, break_delay_r});
          if ((cur_r == ST_STOP || cur_r == ST_BREAK) && in_q_r.speed > start_speed_r) begin
            cur_nxt = (in_q_r.cadence < coast_cad_r) ? ST_COAST : ST_POWER;
            off_nxt = RESUME_MINUTES;
          end else begin
            if (brk_move) begin
              cur_nxt = ST_BREAK;
            end
            sleep = (off_r != OFF_NEVER) && (el > {8'b0, lim_old});
          end
        end
      end
      OP_CONNECT: begin
        if (cur_r == ST_NOLINK) begin
          cur_nxt = held_r;
          if (held_r == ST_STOP) begin
            stop_nxt = in_q_r.now_ms;
          end
        end
      end
      OP_DISCONNECT: begin
        if (cur_r != ST_NOLINK) begin
          held_nxt = cur_r;
          cur_nxt  = ST_NOLINK;
        end
      end
      OP_EXTEND: begin
        if (off_r != OFF_NEVER && off_r < OFF_MAX &&
            {9'b0, lim_old} < ({1'b0, el} + BLINK_MS)) begin
          off_nxt = off_r + 8'd1;
        end
      end
      OP_TOGGLE: begin
        if (off_r == OFF_NEVER) begin
          off_nxt = (el >= TOGGLE_SAT_MS) ? OFF_MAX
                  : tog_prod[DIV60K_SHIFT +: 8] + RESUME_MINUTES;
        end else begin
          off_nxt = OFF_NEVER;
        end
      end
      default: begin
      end
    endcase

    // slot counters, all slots in parallel
    for (int c = 0; c < NUM_SLOTS; c++) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        cnt_nxt[c][s] = cnt_r[c][s] +
                        ((in_q_r.op == OP_TICK && cur_r[s]) ? delta : 32'd0);
      end
      stop_sum = cnt_nxt[c][ST_IDX_STOP];
      amt      = (stop_sum >= el) ? el : stop_sum;
      if (brk_move) begin
        cnt_nxt[c][ST_IDX_STOP]  = stop_sum - amt;
        cnt_nxt[c][ST_IDX_BREAK] = cnt_nxt[c][ST_IDX_BREAK] + amt;
      end
      if (in_q_r.op == OP_CLEAR && int'(in_q_r.slot) == c) begin
        for (int s = 0; s < NUM_STATES; s++) begin
          cnt_nxt[c][s] = 32'd0;
        end
      end
    end

    // slot read
    for (int s = 0; s < NUM_STATES; s++) begin
      row[s] = 32'd0;
    end
    for (int c = 0; c < NUM_SLOTS; c++) begin
      if (int'(in_q_r.slot) == c) begin
        row = cnt_r[c];
      end
    end
    in_rng = int'(in_q_r.slot) < NUM_SLOTS;
    t = row[ST_IDX_COAST] + row[ST_IDX_POWER]
      + ((in_q_r.avg_kind == KIND_ALL) ? row[ST_IDX_BREAK] : 32'd0)
      + ((in_q_r.avg_kind == KIND_ALL || in_q_r.avg_kind == KIND_NO_BREAK)
         ? row[ST_IDX_STOP] : 32'd0);

    // icon inputs after the event
    el2     = in_q_r.now_ms - stop_nxt;
    lim_new = min_to_ms(off_nxt);

    mid_nxt.drive_state = state_code(cur_nxt);
    mid_nxt.sleep       = sleep;
    mid_nxt.off         = off_nxt;
    mid_nxt.el          = el2;
    mid_nxt.t           = (in_q_r.op == OP_READ && in_rng) ? t : 32'd0;
    mid_nxt.icon_base   = ICON_NEUTRAL;
    mid_nxt.blink       = 1'b0;
    mid_nxt.crit        = 1'b0;
    if (cur_nxt == ST_NOLINK || cur_nxt == ST_BREAK) begin
      if (off_nxt == OFF_NEVER) begin
        mid_nxt.icon_base = ICON_OK;
      end else begin
        mid_nxt.blink = {9'b0, lim_new} < ({1'b0, el2} + BLINK_MS);
        mid_nxt.crit  = {9'b0, lim_new} < ({1'b0, el2} + CRIT_MS);
      end
    end
  end

  // result stage, divide by 1000
  always_comb begin
    prod_t  = 61'(mid_r.t) * 61'(DIV1000_RECIP);
    prod_el = 61'(mid_r.el) * 61'(DIV1000_RECIP);
    out_nxt.drive_state     = mid_r.drive_state;
    out_nxt.sleep_request   = mid_r.sleep;
    out_nxt.off_minutes_now = mid_r.off;
    out_nxt.time_seconds    = prod_t[DIV1000_SHIFT +: 23];
    if (mid_r.blink && prod_el[DIV1000_SHIFT]) begin
      out_nxt.icon_color = mid_r.crit ? ICON_CRIT : ICON_WARN;
    end else begin
      out_nxt.icon_color = mid_r.icon_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      start_speed_r <= START_SPEED_RST;
      stop_speed_r  <= STOP_SPEED_RST;
      coast_cad_r   <= COAST_CADENCE_RST;
      power_cad_r   <= POWER_CADENCE_RST;
      break_delay_r <= BREAK_DELAY_RST;
      off_r         <= OFF_MINUTES_RST;
      cur_r         <= ST_NOLINK;
      held_r        <= ST_STOP;
      last_r        <= 32'd0;
      stop_r        <= 32'd0;
      for (int c = 0; c < NUM_SLOTS; c++) begin
        for (int s = 0; s < NUM_STATES; s++) begin
          cnt_r[c][s] <= 32'd0;
        end
      end
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (!s2_vld_r || out_adv) begin
        s2_vld_r <= s1_vld_r;
      end
      if (!out_vld_r || out_ready) begin
        out_vld_r <= s2_vld_r;
      end
      if (s2_adv) begin
        cur_r  <= cur_nxt;
        held_r <= held_nxt;
        off_r  <= off_nxt;
        last_r <= last_nxt;
        stop_r <= stop_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_SPEED:   start_speed_r <= cfg_wdata[13:0];
          CFG_STOP_SPEED:    stop_speed_r  <= cfg_wdata[13:0];
          CFG_COAST_CADENCE: coast_cad_r   <= cfg_wdata[8:0];
          CFG_POWER_CADENCE: power_cad_r   <= cfg_wdata[8:0];
          CFG_BREAK_DELAY:   break_delay_r <= cfg_wdata[23:0];
          CFG_OFF_MINUTES:   off_r         <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (s2_adv) begin
      mid_r <= mid_nxt;
    end
    if (out_adv) begin
      out_r <= out_nxt;
    end
  end

  // checks
  a_s2_load: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> s2_vld_r)
    else $error("word lost between state stage and result stage");

  a_sleep_never: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.sleep_request && out_r.off_minutes_now == OFF_NEVER))
    else $error("sleep request with auto-off disabled");

  a_icon_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.icon_color == ICON_OK) |->
      (out_r.off_minutes_now == OFF_NEVER &&
       (out_r.drive_state == ST_CODE_NOLINK || out_r.drive_state == ST_CODE_BREAK)))
    else $error("ok icon outside idle states or with auto-off enabled");

  a_moving_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r &&
     (out_r.drive_state == ST_CODE_COAST || out_r.drive_state == ST_CODE_POWER)) |->
      (out_r.icon_color == ICON_NEUTRAL && !out_r.sleep_request))
    else $error("icon or sleep request while moving");

endmodule

[tb/ride_state_time_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_state_time_tracker_tb: self-checking bench for the ride state tracker
// Drives event words through the valid/ready input with random gaps, stalls
// the result side at random, and checks every result word against a
// cycle-free software copy of the tracker held in a scoreboard class. The
// configuration registers are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module ride_state_time_tracker_tb
  import rstt_pkg::*;
;

  localparam int SLOTS = 4;
  localparam logic [2:0] OP_NOP = 3'd7;

  class ride_status_board;
    bit [13:0] start_spd, stop_spd;
    bit [8:0]  coast_cad, power_cad;
    bit [23:0] break_ms;
    bit [7:0]  init_off, off_min;
    bit [2:0]  cur_state, held_state;
    bit [31:0] last_tick, stop_mark;
    bit [31:0] ms_in [NUM_STATES][SLOTS];
    out_word_t awaited[$];
    int        errors;

    function new();
      start_spd  = START_SPEED_RST;
      stop_spd   = STOP_SPEED_RST;
      coast_cad  = COAST_CADENCE_RST;
      power_cad  = POWER_CADENCE_RST;
      break_ms   = BREAK_DELAY_RST;
      init_off   = OFF_MINUTES_RST;
      off_min    = OFF_MINUTES_RST;
      cur_state  = ST_CODE_NOLINK;
      held_state = ST_CODE_STOP;
      last_tick  = '0;
      stop_mark  = '0;
      foreach (ms_in[s, c]) ms_in[s][c] = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_START_SPEED:   start_spd = val[13:0];
        CFG_STOP_SPEED:    stop_spd  = val[13:0];
        CFG_COAST_CADENCE: coast_cad = val[8:0];
        CFG_POWER_CADENCE: power_cad = val[8:0];
        CFG_BREAK_DELAY:   break_ms  = val[23:0];
        CFG_OFF_MINUTES: begin
          init_off = val[7:0];
          off_min  = val[7:0];
        end
        default: ;
      endcase
    endfunction

    function void enter(bit [2:0] s, bit [31:0] now);
      cur_state = s;
      if (s == ST_CODE_STOP) stop_mark = now;
    endfunction

    // auto-off budget minus time since the stop mark, signed
    function longint ms_left(bit [31:0] now);
      bit [31:0] el;
      longint    budget, spent;
      el     = now - stop_mark;
      budget = off_min * MS_PER_MIN;
      spent  = el;
      return budget - spent;
    endfunction

    function bit [1:0] icon_at(bit [31:0] now);
      bit [31:0] el;
      longint    left;
      if (cur_state != ST_CODE_NOLINK && cur_state != ST_CODE_BREAK) return ICON_NEUTRAL;
      if (off_min == OFF_NEVER) return ICON_OK;
      el   = now - stop_mark;
      left = ms_left(now);
      if (left < 60000 && (el / 1000) % 2 == 1)
        return (left < 10000) ? ICON_CRIT : ICON_WARN;
      return ICON_NEUTRAL;
    endfunction

    function bit run_tick(bit [31:0] now, bit [13:0] spd, bit [8:0] cad);
      bit [31:0] delta, el, amt, off_ms;
      int        c;
      delta     = now - last_tick;
      el        = now - stop_mark;
      last_tick = now;
      for (c = 0; c < SLOTS; c++) ms_in[cur_state][c] += delta;
      if (cur_state == ST_CODE_COAST || cur_state == ST_CODE_POWER) begin
        stop_mark = now;
        if (spd < stop_spd) enter(ST_CODE_STOP, now);
        else if (cad < coast_cad && cur_state == ST_CODE_POWER) enter(ST_CODE_COAST, now);
        else if (cad > power_cad && cur_state == ST_CODE_COAST) enter(ST_CODE_POWER, now);
        return 1'b0;
      end
      if (cur_state == ST_CODE_STOP && el > {8'd0, break_ms}) begin
        // each slot moves at most what its own stop counter holds
        for (c = 0; c < SLOTS; c++) begin
          amt = (ms_in[ST_CODE_STOP][c] >= el) ? el : ms_in[ST_CODE_STOP][c];
          ms_in[ST_CODE_STOP][c]  -= amt;
          ms_in[ST_CODE_BREAK][c] += amt;
        end
        enter(ST_CODE_BREAK, now);
      end
      if ((cur_state == ST_CODE_STOP || cur_state == ST_CODE_BREAK) && spd > start_spd) begin
        enter((cad < coast_cad) ? ST_CODE_COAST : ST_CODE_POWER, now);
        off_min = RESUME_MINUTES;
        el      = '0;
      end
      off_ms = off_min * MS_PER_MIN;
      return (off_min != OFF_NEVER) && (el > off_ms);
    endfunction

    function out_word_t predict_status(in_word_t w);
      out_word_t r;
      bit [31:0] el, m, t;
      int        d;
      r = '0;
      case (w.op)
        OP_TICK: r.sleep_request = run_tick(w.now_ms, w.speed, w.cadence);
        OP_CONNECT: if (cur_state == ST_CODE_NOLINK) enter(held_state, w.now_ms);
        OP_DISCONNECT: begin
          if (cur_state != ST_CODE_NOLINK) begin
            held_state = cur_state;
            cur_state  = ST_CODE_NOLINK;
          end
        end
        OP_EXTEND: begin
          if (off_min != OFF_NEVER && ms_left(w.now_ms) < 60000 && off_min < OFF_MAX)
            off_min++;
        end
        OP_TOGGLE: begin
          if (off_min == OFF_NEVER) begin
            el      = w.now_ms - stop_mark;
            m       = el / MS_PER_MIN + RESUME_MINUTES;
            off_min = (m > OFF_MAX) ? OFF_MAX : m[7:0];
          end else begin
            off_min = OFF_NEVER;
          end
        end
        OP_CLEAR: for (d = 0; d < NUM_STATES; d++) ms_in[d][w.slot] = '0;
        OP_READ: begin
          t = ms_in[ST_CODE_COAST][w.slot] + ms_in[ST_CODE_POWER][w.slot];
          if (w.avg_kind == KIND_ALL) t += ms_in[ST_CODE_BREAK][w.slot];
          if (w.avg_kind <= KIND_NO_BREAK) t += ms_in[ST_CODE_STOP][w.slot];
          r.time_seconds = 23'(t / 1000);
        end
        default: ;
      endcase
      r.drive_state     = cur_state;
      r.icon_color      = icon_at(w.now_ms);
      r.off_minutes_now = off_min;
      return r;
    endfunction

    function void note_input(in_word_t w);
      awaited.push_back(predict_status(w));
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= 100)
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        report("result word with nothing awaited, state", got.drive_state, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.drive_state !== want.drive_state)
        report("drive_state", got.drive_state, want.drive_state);
      if (got.icon_color !== want.icon_color)
        report("icon_color", got.icon_color, want.icon_color);
      if (got.sleep_request !== want.sleep_request)
        report("sleep_request", got.sleep_request, want.sleep_request);
      if (got.off_minutes_now !== want.off_minutes_now)
        report("off_minutes_now", got.off_minutes_now, want.off_minutes_now);
      if (got.time_seconds !== want.time_seconds)
        report("time_seconds", got.time_seconds, want.time_seconds);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  ride_status_board status_board = new();
  bit               steady_run;
  bit [31:0]        clock_ms;

  ride_state_time_tracker #(
    .NUM_SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, none during the steady stretch
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) status_board.check_result(out_data);
      out_ready <= steady_run || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (!steady_run && $urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    status_board.note_input(w);
  endtask

  task automatic put(input logic [2:0] op, input logic [31:0] t, input int spd,
                     input int cad, input int sl, input int kind);
    in_word_t w;
    w.op       = op;
    w.now_ms   = t;
    w.speed    = 14'(spd);
    w.cadence  = 9'(cad);
    w.slot     = 2'(sl);
    w.avg_kind = 2'(kind);
    send_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    status_board.set_reg(idx, val);
  endtask

  task automatic apply_settings(input int start, input int stop, input int coast,
                                input int power, input int brk, input int off);
    write_reg(CFG_START_SPEED, CFG_W'(start));
    write_reg(CFG_STOP_SPEED, CFG_W'(stop));
    write_reg(CFG_COAST_CADENCE, CFG_W'(coast));
    write_reg(CFG_POWER_CADENCE, CFG_W'(power));
    write_reg(CFG_BREAK_DELAY, CFG_W'(brk));
    write_reg(CFG_OFF_MINUTES, CFG_W'(off));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t  w;
    int        pick;
    bit [31:0] step;
    case ($urandom_range(49))
      0:             step = $urandom;
      1, 2, 3, 4:    step = $urandom_range(200000, 4000000);
      5, 6, 7, 8, 9,
      10, 11, 12:    step = $urandom_range(1500, 200000);
      default:       step = $urandom_range(0, 1500);
    endcase
    clock_ms   = clock_ms + step;
    w.now_ms   = clock_ms;
    w.slot     = 2'($urandom_range(3));
    w.avg_kind = 2'($urandom_range(3));
    case ($urandom_range(9))
      0, 1, 2: w.speed = 14'($urandom_range(0, 60));
      3:       w.speed = 14'($urandom_range(0, 10000));
      4:       w.speed = $urandom_range(1) ? 14'd10000 : 14'd0;
      default: w.speed = 14'($urandom_range(600, 10000));
    endcase
    case ($urandom_range(5))
      0:       w.cadence = 9'($urandom_range(0, 511));
      1:       w.cadence = $urandom_range(1) ? 9'd511 : 9'd0;
      default: w.cadence = 9'($urandom_range(20, 70));
    endcase
    pick = $urandom_range(99);
    if (pick < 62)      w.op = OP_TICK;
    else if (pick < 68) w.op = OP_CONNECT;
    else if (pick < 71) w.op = OP_DISCONNECT;
    else if (pick < 75) w.op = OP_EXTEND;
    else if (pick < 79) w.op = OP_TOGGLE;
    else if (pick < 84) w.op = OP_CLEAR;
    else if (pick < 99) w.op = OP_READ;
    else                w.op = OP_NOP;
    return w;
  endfunction

  task automatic directed_words();
    put(OP_READ, 0, 0, 0, 0, KIND_ALL);
    put(OP_TICK, 1000, 0, 0, 0, 0);
    put(OP_NOP, 1500, 0, 0, 0, 0);
    put(OP_CONNECT, 2000, 0, 0, 0, 0);
    put(OP_CONNECT, 2100, 0, 0, 0, 0);
    put(OP_TICK, 3000, 10000, 0, 0, 0);
    put(OP_TICK, 4000, 1000, 511, 0, 0);
    put(OP_TICK, 5000, 1000, 0, 0, 0);
    put(OP_TICK, 6000, 0, 0, 0, 0);
    put(OP_TICK, 200000, 0, 0, 0, 0);
    put(OP_CLEAR, 200500, 0, 0, 1, 0);
    put(OP_TICK, 200600, 600, 45, 0, 0);
    put(OP_TICK, 201000, 0, 0, 0, 0);
    // slot 2 is cleared while stopped, so the break move leaves its stop counter at zero
    put(OP_CLEAR, 300000, 0, 0, 2, 0);
    put(OP_TICK, 400000, 0, 0, 0, 0);
    put(OP_READ, 400010, 0, 0, 0, KIND_ALL);
    put(OP_READ, 400020, 0, 0, 1, KIND_NO_BREAK);
    put(OP_READ, 400030, 0, 0, 2, 2);
    put(OP_READ, 400040, 0, 0, 3, 3);
    put(OP_DISCONNECT, 400100, 0, 0, 0, 0);
    put(OP_EXTEND, 400300, 0, 0, 0, 0);
    put(OP_TOGGLE, 400400, 0, 0, 0, 0);
    put(OP_TICK, 500000, 0, 0, 0, 0);
    put(OP_TOGGLE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    put(OP_EXTEND, 32'hFFFF_FFFF, 0, 0, 0, 0);
    put(OP_TICK, 32'hFFFF_FFFF, 10000, 511, 3, 3);
    put(OP_CONNECT, 32'h7FFF_F000, 0, 0, 0, 0);
    put(OP_TICK, 32'h7FFF_FFFF, 0, 511, 0, 0);
    put(OP_READ, 32'h8000_0000, 0, 0, 0, KIND_ALL);
  endtask

  initial begin
    int ph;
    int i;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_START_SPEED;
    cfg_wdata  <= '0;
    steady_run  = 1'b0;
    clock_ms    = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: apply_settings(0, 0, 0, 0, 0, 0);
        1: apply_settings(10000, 10000, 511, 511, 16777215, 255);
        2: apply_settings(550, 30, 40, 50, 3000, 1);
        3: apply_settings($urandom_range(0, 3000), $urandom_range(0, 300),
                          $urandom_range(0, 60), $urandom_range(30, 120),
                          $urandom_range(0, 20000),
                          $urandom_range(1) ? 255 : $urandom_range(0, 3));
        4: apply_settings(550, 30, 40, 50, 120000, 50);
        default: apply_settings(200, 100, 60, 20, 500, 254);
      endcase
      steady_run = (ph == 2);
      for (i = 0; i < 85; i++) send_word(random_word());
      steady_run = 1'b0;
    end
    settle();
    if (status_board.errors == 0 && status_board.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
